// ----- sv/ssq_pkg.sv -----
// shared types and codes of the sorted priority queue
package ssq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_BADPRIO = 3'd3;
  localparam logic [2:0] STAT_RANGE   = 3'd4;

  localparam logic [1:0] PRIO_NONE = 2'd0;

  localparam int FIELD_TAG_W = 16;
  localparam int INDEX_W     = 7;
  localparam int OCC_W       = 8;

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic       ins;
    logic       pop;
    logic       rd_load;
    logic       rd_shift;
    logic [1:0] prio;
  } cell_cmd_t;

endpackage

// ----- sv/ssq_cell.sv -----
// one storage cell of the sorted chain, with its stage of the read shift line
module ssq_cell #(
  parameter int INDEX    = 0,
  parameter int CNT_W    = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  ssq_pkg::cell_cmd_t    cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  logic [1:0]            left_prio,
  input  logic [TAG_BITS-1:0]   left_tag,
  input  logic [1:0]            right_prio,
  input  logic [TAG_BITS-1:0]   right_tag,
  input  logic [1:0]            right_rd_prio,
  input  logic [TAG_BITS-1:0]   right_rd_tag,
  output logic [1:0]            prio,
  output logic [TAG_BITS-1:0]   tag,
  output logic [1:0]            rd_prio,
  output logic [TAG_BITS-1:0]   rd_tag
);

  logic [1:0]          prio_r, prio_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [1:0]          rd_prio_r, rd_prio_nxt;
  logic [TAG_BITS-1:0] rd_tag_r, rd_tag_nxt;
  logic                occupied;
  logic                left_le;

  always_comb begin
    occupied = CNT_W'(INDEX) < count;
    // head cell has nothing ahead of it, so a new entry always fits there
    left_le  = (INDEX == 0) || (left_prio <= cmd.prio);

    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (cmd.ins) begin
      if (occupied && (prio_r <= cmd.prio)) begin
        prio_nxt = prio_r;
        tag_nxt  = tag_r;
      end else if (left_le) begin
        prio_nxt = cmd.prio;
        tag_nxt  = new_tag;
      end else begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end
    end else if (cmd.pop) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end

    rd_prio_nxt = rd_prio_r;
    rd_tag_nxt  = rd_tag_r;
    if (cmd.rd_load) begin
      rd_prio_nxt = prio_r;
      rd_tag_nxt  = tag_r;
    end else if (cmd.rd_shift) begin
      rd_prio_nxt = right_rd_prio;
      rd_tag_nxt  = right_rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    tag_r     <= tag_nxt;
    rd_prio_r <= rd_prio_nxt;
    rd_tag_r  <= rd_tag_nxt;
  end

  assign prio    = prio_r;
  assign tag     = tag_r;
  assign rd_prio = rd_prio_r;
  assign rd_tag  = rd_tag_r;

endmodule

// ----- sv/ssq_ctrl.sv -----
// handshake, entry count, read sequencing and result register of the queue
module ssq_ctrl #(
  parameter int DEPTH    = 128,
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [ssq_pkg::FIELD_TAG_W-1:0]    in_tag,
  input  logic [1:0]                         in_priority_req,
  input  logic [ssq_pkg::INDEX_W-1:0]        in_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_status,
  output logic [ssq_pkg::FIELD_TAG_W-1:0]    out_tag,
  output logic [1:0]                         out_priority,
  output logic [ssq_pkg::OCC_W-1:0]          out_occupancy,
  output ssq_pkg::cell_cmd_t                 cmd,
  output logic [CNT_W-1:0]                   count,
  output logic [TAG_BITS-1:0]                new_tag,
  input  logic [1:0]                         head_prio,
  input  logic [TAG_BITS-1:0]                head_tag,
  input  logic [1:0]                         rd_head_prio,
  input  logic [TAG_BITS-1:0]                rd_head_tag
);

  localparam int TW = (TAG_BITS < ssq_pkg::FIELD_TAG_W) ? TAG_BITS : ssq_pkg::FIELD_TAG_W;
  localparam int CW = (CNT_W > ssq_pkg::INDEX_W) ? CNT_W : ssq_pkg::INDEX_W;

  ssq_pkg::state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [ssq_pkg::INDEX_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [2:0]                       status_r, status_nxt;
  logic [ssq_pkg::FIELD_TAG_W-1:0]  otag_r, otag_nxt;
  logic [1:0]                       oprio_r, oprio_nxt;
  logic [ssq_pkg::OCC_W-1:0]        occ_r, occ_nxt;
  logic                             slot_free;
  logic                             in_fire;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ssq_pkg::S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign new_tag   = TAG_BITS'(in_tag[TW-1:0]);
  assign count     = count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    otag_nxt      = otag_r;
    oprio_nxt     = oprio_r;
    occ_nxt       = occ_r;
    cmd           = '0;
    cmd.prio      = in_priority_req;

    unique case (state_r)
      ssq_pkg::S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ssq_pkg::STAT_OK;
          otag_nxt      = '0;
          oprio_nxt     = ssq_pkg::PRIO_NONE;
          case (in_operation)
            ssq_pkg::OP_INSERT: begin
              if (in_priority_req == ssq_pkg::PRIO_NONE) begin
                status_nxt = ssq_pkg::STAT_BADPRIO;
              end else if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ssq_pkg::STAT_FULL;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ssq_pkg::OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ssq_pkg::STAT_EMPTY;
              end else begin
                cmd.pop   = 1'b1;
                otag_nxt  = ssq_pkg::FIELD_TAG_W'(head_tag[TW-1:0]);
                oprio_nxt = head_prio;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ssq_pkg::OP_READ: begin
              if (count_r == '0) begin
                status_nxt = ssq_pkg::STAT_EMPTY;
              end else if (CW'(in_index) >= CW'(count_r)) begin
                status_nxt = ssq_pkg::STAT_RANGE;
              end else begin
                // snapshot the chain into the read line, walk it towards the head
                cmd.rd_load   = 1'b1;
                rd_cnt_nxt    = in_index;
                out_valid_nxt = 1'b0;
                state_nxt     = ssq_pkg::S_READ;
              end
            end
            default: begin
              status_nxt = ssq_pkg::STAT_OK;
            end
          endcase
          occ_nxt = ssq_pkg::OCC_W'(count_nxt);
        end
      end
      ssq_pkg::S_READ: begin
        if (rd_cnt_r != '0) begin
          cmd.rd_shift = 1'b1;
          rd_cnt_nxt   = rd_cnt_r - ssq_pkg::INDEX_W'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ssq_pkg::STAT_OK;
          otag_nxt      = ssq_pkg::FIELD_TAG_W'(rd_head_tag[TW-1:0]);
          oprio_nxt     = rd_head_prio;
          occ_nxt       = ssq_pkg::OCC_W'(count_r);
          state_nxt     = ssq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssq_pkg::S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    otag_r   <= otag_nxt;
    oprio_r  <= oprio_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_tag       = otag_r;
  assign out_priority  = oprio_r;
  assign out_occupancy = occ_r;

endmodule

// ----- sv/stable_sorted_priority_queue.sv -----
// top level of the stable sorted priority queue: controller and chain of cells
//
// Input channel in_valid/in_ready carries one operation per transaction:
// insert (tag with priority 1..3), pop of the head entry, or read at an index.
// Result channel out_valid/out_ready returns one transaction per operation with
// a status, the popped or read entry and the occupancy after the operation.
// Entries sit in a row of DEPTH cells kept sorted by priority; equal priorities
// stay in arrival order. Insert shifts the cells behind the new entry and pop
// shifts all cells one place at once; the result is registered the cycle after.
// A read loads a snapshot of the row into a shift line and moves it index
// places towards the head, one cell per cycle, and its head becomes the result.
// Insert, pop and rejected operations sustain one transaction per cycle while
// the receiver keeps up; the queue takes no new operation during a read.
// A single result register sits on the output: when it is full and out_ready
// is low, in_ready drops until the result is taken.
// Reset (rst_n, synchronous, active low) empties the queue at once; cell
// contents are not cleared and are only ever seen once written.
module stable_sorted_priority_queue #(
  parameter int DEPTH    = 128,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_tag,
  input  logic [1:0]  in_priority_req,
  input  logic [6:0]  in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_tag,
  output logic [1:0]  out_priority,
  output logic [7:0]  out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  ssq_pkg::cell_cmd_t   cmd;
  logic [CNT_W-1:0]     count;
  logic [TAG_BITS-1:0]  new_tag;
  logic [1:0]           prio_w    [DEPTH+1];
  logic [TAG_BITS-1:0]  tag_w     [DEPTH+1];
  logic [1:0]           rd_prio_w [DEPTH+1];
  logic [TAG_BITS-1:0]  rd_tag_w  [DEPTH+1];

  // past the tail the chain reads zeros
  assign prio_w[DEPTH]    = '0;
  assign tag_w[DEPTH]     = '0;
  assign rd_prio_w[DEPTH] = '0;
  assign rd_tag_w[DEPTH]  = '0;

  ssq_ctrl #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tag          (in_tag),
    .in_priority_req (in_priority_req),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy),
    .cmd             (cmd),
    .count           (count),
    .new_tag         (new_tag),
    .head_prio       (prio_w[0]),
    .head_tag        (tag_w[0]),
    .rd_head_prio    (rd_prio_w[0]),
    .rd_head_tag     (rd_tag_w[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT = (i == 0) ? 0 : i - 1;

    ssq_cell #(
      .INDEX    (i),
      .CNT_W    (CNT_W),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .count         (count),
      .new_tag       (new_tag),
      .left_prio     (prio_w[LEFT]),
      .left_tag      (tag_w[LEFT]),
      .right_prio    (prio_w[i+1]),
      .right_tag     (tag_w[i+1]),
      .right_rd_prio (rd_prio_w[i+1]),
      .right_rd_tag  (rd_tag_w[i+1]),
      .prio          (prio_w[i]),
      .tag           (tag_w[i]),
      .rd_prio       (rd_prio_w[i]),
      .rd_tag        (rd_tag_w[i])
    );
  end

endmodule

// ----- dv/ssq_queue_checker.sv -----
// watches both channels of the sorted priority queue, predicts each result and compares it
module ssq_queue_checker #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_tag,
  input  logic [1:0]  in_priority_req,
  input  logic [6:0]  in_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_tag,
  input  logic [1:0]  out_priority,
  input  logic [7:0]  out_occupancy,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag;
    logic [1:0]  prio;
    logic [7:0]  occupancy;
  } queue_outcome_t;

  // shadow copy of the queue contents, head at position 0
  logic [15:0]    queue_tags [DEPTH];
  logic [1:0]     queue_prios [DEPTH];
  int             queue_len = 0;
  queue_outcome_t outcomes_due [$];

  function automatic queue_outcome_t apply_operation(input logic [1:0] op,
                                                      input logic [15:0] tag,
                                                      input logic [1:0] prio,
                                                      input logic [6:0] index);
    queue_outcome_t res;
    int pos;
    res.status = ssq_pkg::STAT_OK;
    res.tag    = '0;
    res.prio   = ssq_pkg::PRIO_NONE;
    case (op)
      ssq_pkg::OP_INSERT: begin
        if (prio == ssq_pkg::PRIO_NONE) begin
          res.status = ssq_pkg::STAT_BADPRIO;
        end else if (queue_len >= DEPTH) begin
          res.status = ssq_pkg::STAT_FULL;
        end else begin
          // lands behind every entry of equal or more urgent priority
          pos = queue_len;
          while (pos > 0 && queue_prios[pos-1] > prio) begin
            queue_tags[pos]  = queue_tags[pos-1];
            queue_prios[pos] = queue_prios[pos-1];
            pos--;
          end
          queue_tags[pos]  = tag;
          queue_prios[pos] = prio;
          queue_len++;
        end
      end
      ssq_pkg::OP_POP: begin
        if (queue_len == 0) begin
          res.status = ssq_pkg::STAT_EMPTY;
        end else begin
          res.tag  = queue_tags[0];
          res.prio = queue_prios[0];
          for (int i = 0; i + 1 < queue_len; i++) begin
            queue_tags[i]  = queue_tags[i+1];
            queue_prios[i] = queue_prios[i+1];
          end
          queue_len--;
        end
      end
      ssq_pkg::OP_READ: begin
        if (queue_len == 0) begin
          res.status = ssq_pkg::STAT_EMPTY;
        end else if (int'(index) >= queue_len) begin
          res.status = ssq_pkg::STAT_RANGE;
        end else begin
          res.tag  = queue_tags[index];
          res.prio = queue_prios[index];
        end
      end
      default: ;
    endcase
    res.occupancy = 8'(queue_len);
    return res;
  endfunction

  task automatic log_mismatch(input string what, input int unsigned want,
                              input int unsigned got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    queue_outcome_t due;
    if (!rst_n) begin
      queue_len = 0;
      outcomes_due.delete();
    end else begin
      // results are registered, so a result taken now never belongs to this edge's operation
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with no operation outstanding, status %0d tag %0h",
                     $time, out_status, out_tag);
          end
          mismatches++;
        end else begin
          due = outcomes_due.pop_front();
          if (out_status !== due.status) log_mismatch("status", due.status, out_status);
          if (out_tag !== due.tag) log_mismatch("tag", due.tag, out_tag);
          if (out_priority !== due.prio) log_mismatch("priority", due.prio, out_priority);
          if (out_occupancy !== due.occupancy) begin
            log_mismatch("occupancy", due.occupancy, out_occupancy);
          end
        end
      end
      if (in_valid && in_ready) begin
        outcomes_due.push_back(apply_operation(in_operation, in_tag, in_priority_req,
                                               in_index));
      end
    end
    outstanding = outcomes_due.size();
  end

endmodule

// ----- dv/tb_stable_sorted_priority_queue.sv -----
// stimulus and verdict for the stable sorted priority queue regression
module tb_stable_sorted_priority_queue;

  localparam int         DEPTH        = 128;
  localparam int         ITEM_TARGET  = 1900;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = ssq_pkg::OP_INSERT;
  logic [15:0] in_tag = '0;
  logic [1:0]  in_priority_req = ssq_pkg::PRIO_NONE;
  logic [6:0]  in_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_tag;
  logic [1:0]  out_priority;
  logic [7:0]  out_occupancy;

  int mismatches;
  int outstanding;

  // rough fill level, only used to steer the stimulus
  int held = 0;
  int issued = 0;
  bit quiet_sender = 1'b0;
  bit quiet_sink = 1'b0;
  int taken = 0;
  int sink_wait = 0;

  stable_sorted_priority_queue #(.DEPTH(DEPTH), .TAG_BITS(16)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tag          (in_tag),
    .in_priority_req (in_priority_req),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

  ssq_queue_checker #(.DEPTH(DEPTH)) queue_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tag          (in_tag),
    .in_priority_req (in_priority_req),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stall after each transaction, with stall-free stretches
  always @(posedge clk) begin : sink
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_valid && out_ready) begin
      taken++;
      if (taken % 50 == 0) quiet_sink = ($urandom_range(0, 2) == 0);
      gap = quiet_sink ? 0 : $urandom_range(0, 5);
      out_ready <= (gap == 0);
      sink_wait <= gap;
    end else if (!out_ready) begin
      if (sink_wait <= 1) out_ready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [15:0] tag,
                       input logic [1:0] prio, input logic [6:0] index);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_tag          <= tag;
    in_priority_req <= prio;
    in_index        <= index;
    do @(posedge clk); while (!in_ready);
    if (op == ssq_pkg::OP_INSERT && prio != ssq_pkg::PRIO_NONE && held < DEPTH) held++;
    if (op == ssq_pkg::OP_POP && held > 0) held--;
    if (op != OP_UNUSED) issued++;
  endtask

  function automatic logic [15:0] draw_tag();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] draw_prio();
    if ($urandom_range(0, 15) == 0) return ssq_pkg::PRIO_NONE;
    return 2'($urandom_range(1, 3));
  endfunction

  function automatic logic [6:0] draw_index();
    if (held > 0 && $urandom_range(0, 99) < 85) return 7'($urandom_range(0, held - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  // pick one operation by percentage weights, the remainder goes to the unused code
  task automatic random_item(input int insert_pct, input int pop_pct, input int read_pct);
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < insert_pct) op = ssq_pkg::OP_INSERT;
    else if (r < insert_pct + pop_pct) op = ssq_pkg::OP_POP;
    else if (r < insert_pct + pop_pct + read_pct) op = ssq_pkg::OP_READ;
    else op = OP_UNUSED;
    issue(op, draw_tag(), draw_prio(), draw_index());
  endtask

  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, rejects, ordering and ties, range limits
    issue(ssq_pkg::OP_READ, 16'h0000, ssq_pkg::PRIO_NONE, 7'd0);
    issue(ssq_pkg::OP_POP, 16'hffff, 2'd3, 7'h7f);
    issue(ssq_pkg::OP_INSERT, 16'hffff, ssq_pkg::PRIO_NONE, 7'h7f);
    issue(OP_UNUSED, 16'hffff, 2'd3, 7'h7f);
    issue(ssq_pkg::OP_INSERT, 16'hffff, 2'd3, 7'd0);
    issue(ssq_pkg::OP_INSERT, 16'h0000, 2'd3, 7'd0);
    issue(ssq_pkg::OP_INSERT, 16'h1234, 2'd1, 7'd0);
    issue(ssq_pkg::OP_INSERT, 16'ha5a5, 2'd2, 7'd0);
    issue(ssq_pkg::OP_INSERT, 16'h5a5a, 2'd1, 7'd0);
    for (int i = 0; i < 5; i++) issue(ssq_pkg::OP_READ, 16'h0000, ssq_pkg::PRIO_NONE, 7'(i));
    issue(ssq_pkg::OP_READ, 16'h0000, ssq_pkg::PRIO_NONE, 7'd5);
    issue(ssq_pkg::OP_READ, 16'hffff, 2'd3, 7'h7f);
    issue(OP_UNUSED, 16'h0000, ssq_pkg::PRIO_NONE, 7'd0);
    repeat (5) issue(ssq_pkg::OP_POP, 16'h0000, ssq_pkg::PRIO_NONE, 7'd0);
    issue(ssq_pkg::OP_POP, 16'h0000, ssq_pkg::PRIO_NONE, 7'd0);
    issue(ssq_pkg::OP_READ, 16'h0000, ssq_pkg::PRIO_NONE, 7'd3);

    // random phases: fill to full, drain to empty, or a mixed run
    while (issued < ITEM_TARGET) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      phase = $urandom_range(0, 3);
      if (phase == 0) begin
        while (held < DEPTH) random_item(88, 2, 9);
        repeat (4) random_item(100, 0, 0);
        issue(ssq_pkg::OP_READ, draw_tag(), draw_prio(), 7'h7f);
        repeat (3) random_item(0, 0, 100);
      end else if (phase == 1) begin
        while (held > 0) random_item(5, 80, 14);
        repeat (2) random_item(0, 100, 0);
        random_item(0, 0, 100);
      end else begin
        repeat (60) random_item(40, 35, 23);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("stable_sorted_priority_queue regression: pass");
    end else begin
      $display("stable_sorted_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("stable_sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
